### rtl/core/kctb_pkg.sv
`default_nettype none

package kctb_pkg;

    // Bank size and the width of a slot index.
    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Request codes.
    localparam logic [2:0] REQ_ADD        = 3'd0;
    localparam logic [2:0] REQ_SET_PAUSED = 3'd1;
    localparam logic [2:0] REQ_DELETE     = 3'd2;
    localparam logic [2:0] REQ_DELETE_ALL = 3'd3;
    localparam logic [2:0] REQ_TICK       = 3'd4;
    localparam logic [2:0] REQ_CONFIGURE  = 3'd5;
    localparam logic [2:0] REQ_QUERY      = 3'd6;

    // Result kinds.
    localparam logic [1:0] KIND_STATUS    = 2'd0;
    localparam logic [1:0] KIND_EXPIRY    = 2'd1;
    localparam logic [1:0] KIND_TICK_DONE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // latch the incoming item
        logic exec;         // perform a single-result request and post its status
        logic sweep_start;  // point the sweep at slot zero
        logic sweep;        // process the slot under the sweep index
        logic finish;       // post the tick-finished result
    } kctb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_tick;     // the latched item is a tick
        logic out_free;     // the output register can take a result this cycle
        logic sweep_stall;  // current slot expires but the output register is busy
        logic sweep_last;   // sweep index is on the last slot
    } kctb_stat_t;

endpackage

`default_nettype wire

### rtl/core/kctb_ctrl.sv
`default_nettype none

module kctb_ctrl
    import kctb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  kctb_stat_t      stat,
    output kctb_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.req_tick) begin
                    cmd.sweep_start = 1'b1;
                    state_next      = ST_SWEEP;
                end else if (stat.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (!stat.sweep_stall && stat.sweep_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

### rtl/core/kctb_dp.sv
`default_nettype none

module kctb_dp
    import kctb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  kctb_cmd_t        cmd,
    output kctb_stat_t       stat,
    input  wire logic [2:0]  s_req_type,
    input  wire logic [7:0]  s_timer_key,
    input  wire logic [31:0] s_count_ms,
    input  wire logic        s_paused,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic             m_status_error,
    output logic             m_running,
    output logic [7:0]       m_expired_key,
    output logic             m_last
);

    // Latched request.
    logic [2:0]  req_type_reg;
    logic [7:0]  req_key_reg;
    logic [31:0] req_count_reg;
    logic        req_paused_reg;

    // Slot bank.
    logic        slot_valid_reg  [SLOTS];
    logic [7:0]  slot_key_reg    [SLOTS];
    logic [31:0] slot_count_reg  [SLOTS];
    logic        slot_paused_reg [SLOTS];

    logic [SLOT_W-1:0] sweep_idx_reg;

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic        out_err_reg;
    logic        out_run_reg;
    logic [7:0]  out_key_reg;
    logic        out_last_reg;

    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free_hit;
    logic [SLOT_W-1:0] free_idx;
    logic              out_free;
    logic [31:0]       cur_count;
    logic [31:0]       dec_count;
    logic              sweep_active;
    logic              sweep_expire;
    logic              sweep_step;
    logic              exec_err;
    logic              exec_run;
    logic              out_load;
    logic [1:0]        out_kind_next;
    logic              out_err_next;
    logic              out_run_next;
    logic [7:0]        out_key_next;
    logic              out_last_next;

    // Capture the accepted item.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_type_reg   <= s_req_type;
            req_key_reg    <= s_timer_key;
            req_count_reg  <= s_count_ms;
            req_paused_reg <= s_paused;
        end
    end

    // Lowest valid slot holding the key, and lowest free slot.
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_hit = 1'b0;
        free_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!hit && slot_valid_reg[i] && (slot_key_reg[i] == req_key_reg)) begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (!free_hit && !slot_valid_reg[i]) begin
                free_hit = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign out_free = !out_valid_reg || m_ready;

    // One slot of the tick sweep: saturating decrement and expiry check.
    assign cur_count    = slot_count_reg[sweep_idx_reg];
    assign dec_count    = (cur_count == 32'd0) ? 32'd0 : cur_count - 32'd1;
    assign sweep_active = slot_valid_reg[sweep_idx_reg] && !slot_paused_reg[sweep_idx_reg];
    assign sweep_expire = sweep_active && (dec_count == 32'd0);
    assign sweep_step   = cmd.sweep && !(sweep_expire && !out_free);

    // Status of a single-result request.
    always_comb begin
        exec_err = 1'b0;
        exec_run = 1'b0;
        unique case (req_type_reg)
            REQ_ADD:        exec_err = !free_hit;
            REQ_SET_PAUSED: exec_err = !hit;
            REQ_DELETE:     exec_err = !hit;
            REQ_DELETE_ALL: exec_err = 1'b0;
            REQ_TICK:       exec_err = 1'b0;
            REQ_CONFIGURE:  exec_err = !hit && !free_hit;
            REQ_QUERY: begin
                exec_err = !hit;
                exec_run = hit && !slot_paused_reg[hit_idx];
            end
            default:        exec_err = 1'b1;
        endcase
    end

    // Slot valid marks.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_valid_reg[i] <= 1'b0;
            end
        end else if (cmd.exec) begin
            case (req_type_reg)
                REQ_ADD, REQ_CONFIGURE: begin
                    if (!hit || (req_type_reg == REQ_ADD)) begin
                        if (free_hit) begin
                            slot_valid_reg[free_idx] <= 1'b1;
                        end
                    end
                end
                REQ_DELETE: begin
                    if (hit) begin
                        slot_valid_reg[hit_idx] <= 1'b0;
                    end
                end
                REQ_DELETE_ALL: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        slot_valid_reg[i] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Slot contents; only read while the slot is valid.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            case (req_type_reg)
                REQ_ADD: begin
                    if (free_hit) begin
                        slot_key_reg[free_idx]    <= req_key_reg;
                        slot_count_reg[free_idx]  <= req_count_reg;
                        slot_paused_reg[free_idx] <= req_paused_reg;
                    end
                end
                REQ_SET_PAUSED: begin
                    if (hit) begin
                        slot_paused_reg[hit_idx] <= req_paused_reg;
                    end
                end
                REQ_CONFIGURE: begin
                    if (hit) begin
                        slot_count_reg[hit_idx]  <= req_count_reg;
                        slot_paused_reg[hit_idx] <= req_paused_reg;
                    end else if (free_hit) begin
                        slot_key_reg[free_idx]    <= req_key_reg;
                        slot_count_reg[free_idx]  <= req_count_reg;
                        slot_paused_reg[free_idx] <= req_paused_reg;
                    end
                end
                default: begin
                end
            endcase
        end
        if (sweep_step && sweep_active) begin
            slot_count_reg[sweep_idx_reg] <= dec_count;
            if (sweep_expire) begin
                slot_paused_reg[sweep_idx_reg] <= 1'b1;
            end
        end
    end

    // Sweep index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_idx_reg <= '0;
        end else if (cmd.sweep_start) begin
            sweep_idx_reg <= '0;
        end else if (sweep_step) begin
            sweep_idx_reg <= sweep_idx_reg + SLOT_W'(1);
        end
    end

    // Next result.
    always_comb begin
        out_load      = 1'b0;
        out_kind_next = KIND_STATUS;
        out_err_next  = 1'b0;
        out_run_next  = 1'b0;
        out_key_next  = 8'd0;
        out_last_next = 1'b1;
        if (cmd.exec) begin
            out_load     = 1'b1;
            out_err_next = exec_err;
            out_run_next = exec_run;
        end else if (cmd.finish) begin
            out_load      = 1'b1;
            out_kind_next = KIND_TICK_DONE;
        end else if (cmd.sweep && sweep_expire && out_free) begin
            out_load      = 1'b1;
            out_kind_next = KIND_EXPIRY;
            out_key_next  = slot_key_reg[sweep_idx_reg];
            out_last_next = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_kind_reg <= out_kind_next;
            out_err_reg  <= out_err_next;
            out_run_reg  <= out_run_next;
            out_key_reg  <= out_key_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_kind  = out_kind_reg;
    assign m_status_error = out_err_reg;
    assign m_running      = out_run_reg;
    assign m_expired_key  = out_key_reg;
    assign m_last         = out_last_reg;

    assign stat.req_tick    = (req_type_reg == REQ_TICK);
    assign stat.out_free    = out_free;
    assign stat.sweep_stall = sweep_expire && !out_free;
    assign stat.sweep_last  = (sweep_idx_reg == SLOT_W'(SLOTS - 1));

endmodule

`default_nettype wire

### rtl/core/keyed_countdown_timer_bank_core.sv
// Bank of eight keyed countdown timers. Each request item is taken when the
// block is idle. For add, set paused, delete, delete all, configure and query,
// an accepted item is captured, then the execute state loads its single
// status item into the output register and returns to idle, so the block
// takes a new item only after it is through with the last one. A tick is
// handled by a sweep that visits one slot per cycle while no expiring slot
// waits for a busy output register. Either kind of request is held up while a
// result waits for the output register to be taken. A tick returns one expiry
// item per expiring slot, in slot order, then a tick-finished item with last
// set. The output register lets the block take the next request while a
// result is still waiting downstream.
`default_nettype none

module keyed_countdown_timer_bank_core
    import kctb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_req_type,
    input  wire logic [7:0]  s_timer_key,
    input  wire logic [31:0] s_count_ms,
    input  wire logic        s_paused,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic             m_status_error,
    output logic             m_running,
    output logic [7:0]       m_expired_key,
    output logic             m_last
);

    kctb_cmd_t  cmd;
    kctb_stat_t stat;

    // Sequencer.
    kctb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Slot bank and output register.
    kctb_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_req_type     (s_req_type),
        .s_timer_key    (s_timer_key),
        .s_count_ms     (s_count_ms),
        .s_paused       (s_paused),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_status_error (m_status_error),
        .m_running      (m_running),
        .m_expired_key  (m_expired_key),
        .m_last         (m_last)
    );

    // An accepted item keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready
    ) else $error("input accepted twice in a row");

    // Expiry items never close a request; tick-finished items always do.
    a_expiry_not_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == KIND_EXPIRY)) |-> !m_last
    ) else $error("expiry item marked last");

    a_tick_done_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == KIND_TICK_DONE)) |-> m_last
    ) else $error("tick-finished item not marked last");

    // A running answer only comes in a status item.
    a_running_status: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_running) |-> (m_result_kind == KIND_STATUS)
    ) else $error("running set outside a status item");

    // The sweep never stalls unless a result is waiting downstream.
    a_stall_needs_busy_out: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (cmd.sweep && stat.sweep_stall) |-> (m_valid && !m_ready)
    ) else $error("sweep stalled with a free output register");

endmodule

`default_nettype wire
